### rtl/core/pipr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pipr_pkg;

    // Coordinate and difference widths
    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;

    // Ray from the point to point x plus RAY_LENGTH
    localparam int RAY_LENGTH = 131072;
    localparam int RAY_W      = $clog2(RAY_LENGTH + 1) + 1;
    localparam int RX_W       = RAY_W + 1;
    localparam int FAR_W      = DIFF_W + RAY_W;
    localparam int ORIENT_W   = ((FAR_W > PROD_W) ? FAR_W : PROD_W) + 2;

    localparam logic signed [RAY_W-1:0] RAY_LEN_S = RAY_W'(RAY_LENGTH);

    // Crossing count saturates at MAX_EDGES, held to what 11 bits can show
    localparam int MAX_EDGES = 1024;
    localparam int COUNT_W   = 11;
    localparam int COUNT_MAX = (1 << COUNT_W) - 1;
    localparam int COUNT_CAP = (MAX_EDGES > COUNT_MAX) ? COUNT_MAX : MAX_EDGES;
    localparam logic [COUNT_W-1:0] COUNT_CAP_V = COUNT_W'(COUNT_CAP);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified edge: the orientation products and the box test
    typedef struct packed {
        logic signed [PROD_W-1:0] cross_a;  // dy * (px - x1)
        logic signed [PROD_W-1:0] cross_b;  // dx * (py - y1)
        logic signed [FAR_W-1:0]  ray_term; // dy * RAY_LENGTH
        logic                     box_hit;
        logic                     last;
    } pipr_edge_t;

endpackage

`default_nettype wire

### rtl/core/pipr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pipr_front (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [pipr_pkg::COORD_W-1:0]   point_x,
    input  wire logic signed [pipr_pkg::COORD_W-1:0]   point_y,
    input  wire logic signed [pipr_pkg::COORD_W-1:0]   edge_x0,
    input  wire logic signed [pipr_pkg::COORD_W-1:0]   edge_y0,
    input  wire logic signed [pipr_pkg::COORD_W-1:0]   edge_x1,
    input  wire logic signed [pipr_pkg::COORD_W-1:0]   edge_y1,
    input  wire logic                                  last_edge,
    input  wire logic                                  q_full,
    output logic                                       q_push,
    output pipr_pkg::pipr_edge_t                       q_data
);
    import pipr_pkg::*;

    logic                     advance;

    // Stage 1: differences and bounding box test
    logic                     s1_valid_reg;
    logic signed [DIFF_W-1:0] dy_reg, dx_reg, ax_reg, by_reg;
    logic                     s1_hit_reg, s1_last_reg;

    logic signed [DIFF_W-1:0] dy_next, dx_next, ax_next, by_next;
    logic signed [COORD_W-1:0] ex_min, ex_max, ey_min, ey_max;
    logic signed [RX_W-1:0]   ray_end;
    logic                     hit_next;

    // Stage 2: products
    logic                     s2_valid_reg;
    pipr_edge_t               s2_reg;
    pipr_edge_t               s2_next;

    assign advance  = !(s2_valid_reg && q_full);
    assign in_stall = !advance;
    assign q_push   = s2_valid_reg && !q_full;
    assign q_data   = s2_reg;

    always_comb
    begin
        dy_next = DIFF_W'(edge_y1) - DIFF_W'(edge_y0);
        dx_next = DIFF_W'(edge_x1) - DIFF_W'(edge_x0);
        ax_next = DIFF_W'(point_x) - DIFF_W'(edge_x1);
        by_next = DIFF_W'(point_y) - DIFF_W'(edge_y1);

        ex_min  = (edge_x0 < edge_x1) ? edge_x0 : edge_x1;
        ex_max  = (edge_x0 < edge_x1) ? edge_x1 : edge_x0;
        ey_min  = (edge_y0 < edge_y1) ? edge_y0 : edge_y1;
        ey_max  = (edge_y0 < edge_y1) ? edge_y1 : edge_y0;
        ray_end = RX_W'(point_x) + RX_W'(RAY_LEN_S);

        hit_next = !(RX_W'(ex_min) > ray_end) && !(point_x > ex_max)
                   && !(ey_min > point_y) && !(point_y > ey_max);
    end

    always_comb
    begin
        s2_next.cross_a  = PROD_W'(dy_reg) * PROD_W'(ax_reg);
        s2_next.cross_b  = PROD_W'(dx_reg) * PROD_W'(by_reg);
        s2_next.ray_term = FAR_W'(dy_reg) * FAR_W'(RAY_LEN_S);
        s2_next.box_hit  = s1_hit_reg;
        s2_next.last     = s1_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dy_reg      <= dy_next;
            dx_reg      <= dx_next;
            ax_reg      <= ax_next;
            by_reg      <= by_next;
            s1_hit_reg  <= hit_next;
            s1_last_reg <= last_edge;
            s2_reg      <= s2_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/pipr_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module pipr_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire pipr_pkg::pipr_edge_t  push_data,
    output logic                       full,
    input  wire logic                  pop,
    output logic                       empty,
    output pipr_pkg::pipr_edge_t       head
);
    import pipr_pkg::*;

    pipr_edge_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]       cnt_reg, cnt_next;

    assign full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= QPTR_W'(wr_ptr_reg + QPTR_W'(1));
            if (pop)
                rd_ptr_reg <= QPTR_W'(rd_ptr_reg + QPTR_W'(1));
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue written while full");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("queue read while empty");
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill count out of range");
`endif

endmodule

`default_nettype wire

### rtl/core/pipr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pipr_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              q_empty,
    input  wire pipr_pkg::pipr_edge_t              q_head,
    output logic                                   q_pop,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   inside_res,
    output logic [pipr_pkg::COUNT_W-1:0]           crossings
);
    import pipr_pkg::*;

    logic signed [ORIENT_W-1:0] orient_pt, orient_far;
    logic                       crossed, out_free;
    logic [COUNT_W-1:0]         count_reg, count_next;
    logic                       out_valid_reg;
    logic                       inside_reg;
    logic [COUNT_W-1:0]         crossings_reg;

    always_comb
    begin
        orient_pt  = ORIENT_W'(q_head.cross_a) - ORIENT_W'(q_head.cross_b);
        orient_far = orient_pt + ORIENT_W'(q_head.ray_term);
        // zero orientation at either end counts as a crossing
        crossed = q_head.box_hit
                  && ((orient_pt == '0) || (orient_far == '0)
                      || (orient_pt[ORIENT_W-1] != orient_far[ORIENT_W-1]));
        count_next = count_reg;
        if (crossed && (count_reg < COUNT_CAP_V))
            count_next = count_reg + COUNT_W'(1);
    end

    assign out_free = !out_valid_reg || !out_stall;
    // only the last edge needs a free output register
    assign q_pop    = !q_empty && (!q_head.last || out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
                count_reg <= q_head.last ? '0 : count_next;
            if (q_pop && q_head.last)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && q_head.last)
        begin
            crossings_reg <= count_next;
            inside_reg    <= count_next[0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = inside_reg;
    assign crossings  = crossings_reg;

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= COUNT_CAP_V)
        else $error("crossing count above cap");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (q_pop && q_head.last) |=> (out_valid_reg && (count_reg == '0)))
        else $error("last edge did not produce a result and clear the count");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (q_pop && q_head.last) |-> out_free)
        else $error("result register overwritten while held");
`endif

endmodule

`default_nettype wire

### rtl/core/point_in_polygon_ray_cast.sv
`timescale 1ns / 1ps
`default_nettype none

// Ray-cast point-in-polygon test, one polygon edge per input request.
// Input channel: in_valid / in_stall with the query point, one edge and
// last_edge. Each edge is tested against a horizontal ray from the point
// to point x plus RAY_LENGTH, and crossed edges are counted (saturating).
// Output channel: out_valid / out_stall carrying crossings and inside_res
// (count parity); one request leaves for each edge marked last_edge, and
// the count is then cleared for the next polygon.
// Throughput: one edge per cycle while in_stall is low, through the two-stage
// multiply front end feeding a 4-entry queue and a counting back end.
// A last edge passes both front-end stages and the queue before its result is registered.
// When out_stall holds a result, edges keep flowing until a later last
// edge reaches the back end; then the queue fills and in_stall rises.
// Reset (rst_n low, asynchronous) empties the pipeline and queue, drops
// any pending result and clears the crossing count.
module point_in_polygon_ray_cast (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [pipr_pkg::COORD_W-1:0]   point_x,
    input  wire logic signed [pipr_pkg::COORD_W-1:0]   point_y,
    input  wire logic signed [pipr_pkg::COORD_W-1:0]   edge_x0,
    input  wire logic signed [pipr_pkg::COORD_W-1:0]   edge_y0,
    input  wire logic signed [pipr_pkg::COORD_W-1:0]   edge_x1,
    input  wire logic signed [pipr_pkg::COORD_W-1:0]   edge_y1,
    input  wire logic                                  last_edge,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic                                       inside_res,
    output logic [pipr_pkg::COUNT_W-1:0]               crossings
);
    import pipr_pkg::*;

    logic       q_push, q_full, q_pop, q_empty;
    pipr_edge_t q_in, q_head;

    pipr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .point_x   (point_x),
        .point_y   (point_y),
        .edge_x0   (edge_x0),
        .edge_y0   (edge_y0),
        .edge_x1   (edge_x1),
        .edge_y1   (edge_y1),
        .last_edge (last_edge),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    pipr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    pipr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .inside_res (inside_res),
        .crossings  (crossings)
    );

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import pipr_pkg::*;

    typedef struct {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic                      last;
    } edge_req_t;

    typedef struct {
        logic               in_poly;
        logic [COUNT_W-1:0] count;
    } pip_result_t;

    typedef struct {
        edge_req_t          req;
        bit                 typed;
        logic               t_inside;
        logic [COUNT_W-1:0] t_count;
    } dir_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] edge_x0;
    logic signed [COORD_W-1:0] edge_y0;
    logic signed [COORD_W-1:0] edge_x1;
    logic signed [COORD_W-1:0] edge_y1;
    logic                      last_edge;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic                      inside_res;
    logic [COUNT_W-1:0]        crossings;

    pip_result_t        expected_results[$];
    dir_row_t           dir_rows[$];
    logic [COUNT_W-1:0] model_count;
    int                 send_idle;
    int                 recv_idle;
    int                 items_sent;
    int                 error_count;

    point_in_polygon_ray_cast uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .point_x    (point_x),
        .point_y    (point_y),
        .edge_x0    (edge_x0),
        .edge_y0    (edge_y0),
        .edge_x1    (edge_x1),
        .edge_y1    (edge_y1),
        .last_edge  (last_edge),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .inside_res (inside_res),
        .crossings  (crossings)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic logic signed [COORD_W-1:0] clip16(input int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return COORD_W'(v);
    endfunction

    function automatic int rand_offset(input int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    function automatic bit edge_is_crossed(input edge_req_t r);
        longint px, py, x0, y0, x1, y1, rx1;
        longint xmin, xmax, ymin, ymax, dy, dx, v1, v2;
        px = r.px;
        py = r.py;
        x0 = r.x0;
        y0 = r.y0;
        x1 = r.x1;
        y1 = r.y1;
        rx1 = px + longint'(RAY_LENGTH);
        xmin = (x0 < x1) ? x0 : x1;
        xmax = (x0 < x1) ? x1 : x0;
        ymin = (y0 < y1) ? y0 : y1;
        ymax = (y0 < y1) ? y1 : y0;
        if (xmin > rx1 || px > xmax)
            return 1'b0;
        if (ymin > py || py > ymax)
            return 1'b0;
        dy = y1 - y0;
        dx = x1 - x0;
        v1 = dy * (px - x1) - dx * (py - y1);
        v2 = dy * (rx1 - x1) - dx * (py - y1);
        // zero orientation on either end counts as a crossing
        if (v1 == 0 || v2 == 0)
            return 1'b1;
        return (v1 > 0) != (v2 > 0);
    endfunction

    task automatic send_edge(input edge_req_t r, input bit typed,
                             input logic t_inside, input logic [COUNT_W-1:0] t_count);
        pip_result_t res;
        while (int'($urandom_range(99)) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        point_x   <= r.px;
        point_y   <= r.py;
        edge_x0   <= r.x0;
        edge_y0   <= r.y0;
        edge_x1   <= r.x1;
        edge_y1   <= r.y1;
        last_edge <= r.last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (edge_is_crossed(r) && model_count < COUNT_CAP)
            model_count++;
        if (r.last)
        begin
            res.in_poly = model_count[0];
            res.count   = model_count;
            if (typed)
            begin
                res.in_poly = t_inside;
                res.count   = t_count;
            end
            expected_results.push_back(res);
            model_count = '0;
        end
    endtask

    task automatic add_row(input int px, input int py, input int x0, input int y0,
                           input int x1, input int y1, input bit last,
                           input bit typed, input bit t_inside, input int t_count);
        dir_row_t row;
        row.req.px   = clip16(px);
        row.req.py   = clip16(py);
        row.req.x0   = clip16(x0);
        row.req.y0   = clip16(y0);
        row.req.x1   = clip16(x1);
        row.req.y1   = clip16(y1);
        row.req.last = last;
        row.typed    = typed;
        row.t_inside = t_inside;
        row.t_count  = COUNT_W'(t_count);
        dir_rows.push_back(row);
    endtask

    // Closed polygon around a random center; the point lands near it,
    // sometimes on a vertex or level with one to hit zero orientations.
    task automatic send_polygon(input int n);
        int        cx, cy, rad, px, py, k, i;
        int        vx[$];
        int        vy[$];
        edge_req_t r;
        cx  = int'($urandom_range(32000)) - 16000;
        cy  = int'($urandom_range(32000)) - 16000;
        rad = int'($urandom_range(1 << $urandom_range(14, 1), 1));
        for (i = 0; i < n; i++)
        begin
            vx.push_back(cx + rand_offset(rad));
            vy.push_back(cy + rand_offset(rad));
        end
        k  = int'($urandom_range(n - 1));
        px = cx + rand_offset(rad + rad / 2);
        py = cy + rand_offset(rad + rad / 2);
        case ($urandom_range(5))
            0:
            begin
                px = vx[k];
                py = vy[k];
            end
            1:       py = vy[k];
            default: ;
        endcase
        for (i = 0; i < n; i++)
        begin
            r.px   = clip16(px);
            r.py   = clip16(py);
            r.x0   = clip16(vx[i]);
            r.y0   = clip16(vy[i]);
            r.x1   = clip16(vx[(i + 1) % n]);
            r.y1   = clip16(vy[(i + 1) % n]);
            r.last = (i == n - 1);
            send_edge(r, 1'b0, 1'b0, '0);
        end
    endtask

    // Full-range junk, with the end marker dropped at random
    task automatic send_noise();
        int        k, i;
        edge_req_t r;
        k = int'($urandom_range(8, 1));
        for (i = 0; i < k; i++)
        begin
            r.px   = COORD_W'($urandom);
            r.py   = COORD_W'($urandom);
            r.x0   = COORD_W'($urandom);
            r.y0   = COORD_W'($urandom);
            r.x1   = COORD_W'($urandom);
            r.y1   = COORD_W'($urandom);
            r.last = ($urandom_range(7) == 0);
            send_edge(r, 1'b0, 1'b0, '0);
        end
    endtask

    // Every edge is vertical (or a dot) on or right of the point and spans
    // its y, so each one crosses and the count runs into the cap.
    task automatic send_saturating(input int n);
        int        px, py, x, ya, yb, i;
        edge_req_t r;
        px = int'($urandom_range(65535)) - 32768;
        py = int'($urandom_range(65535)) - 32768;
        for (i = 0; i < n; i++)
        begin
            x  = px + int'($urandom_range(32767 - px));
            ya = py - int'($urandom_range(py + 32768));
            yb = py + int'($urandom_range(32767 - py));
            r.px = clip16(px);
            r.py = clip16(py);
            r.x0 = clip16(x);
            r.x1 = clip16(x);
            r.y0 = clip16($urandom_range(1) ? ya : yb);
            r.y1 = clip16((r.y0 == clip16(ya)) ? yb : ya);
            r.last = (i == n - 1);
            send_edge(r, 1'b0, 1'b0, '0);
        end
    endtask

    task automatic run_random(input int goal);
        while (items_sent < goal)
        begin
            if ($urandom_range(99) < 82)
                send_polygon(($urandom_range(9) == 0) ? int'($urandom_range(40, 13))
                                                      : int'($urandom_range(12, 3)));
            else
                send_noise();
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("result with none pending: inside %0b count %0d",
                                              inside_res, crossings));
                end
                else
                begin
                    if (inside_res !== expected_results[0].in_poly)
                        report_mismatch($sformatf("inside_res %0b, want %0b",
                                                  inside_res, expected_results[0].in_poly));
                    if (crossings !== expected_results[0].count)
                        report_mismatch($sformatf("crossings %0d, want %0d",
                                                  crossings, expected_results[0].count));
                    void'(expected_results.pop_front());
                end
            end
            out_stall <= (int'($urandom_range(99)) < recv_idle);
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        point_x     = '0;
        point_y     = '0;
        edge_x0     = '0;
        edge_y0     = '0;
        edge_x1     = '0;
        edge_y1     = '0;
        last_edge   = 1'b0;
        model_count = '0;
        items_sent  = 0;
        error_count = 0;
        send_idle   = 35;
        recv_idle   = 52;

        // dot above the ray right after reset, then dots on and off the ray
        add_row(0, 0, 100, 100, 100, 100, 1, 1, 0, 0);
        add_row(0, 0, 5, 0, 5, 0, 1, 1, 1, 1);
        add_row(7, -3, 7, -3, 7, -3, 1, 1, 1, 1);
        add_row(0, 0, -1, 0, -1, 0, 1, 1, 0, 0);
        // square around the point, then the same square seen from outside
        add_row(0, 0, -10, -10, 10, -10, 0, 0, 0, 0);
        add_row(0, 0, 10, -10, 10, 10, 0, 0, 0, 0);
        add_row(0, 0, 10, 10, -10, 10, 0, 0, 0, 0);
        add_row(0, 0, -10, 10, -10, -10, 1, 0, 0, 0);
        add_row(-20, 0, -10, -10, 10, -10, 0, 0, 0, 0);
        add_row(-20, 0, 10, -10, 10, 10, 0, 0, 0, 0);
        add_row(-20, 0, 10, 10, -10, 10, 0, 0, 0, 0);
        add_row(-20, 0, -10, 10, -10, -10, 1, 0, 0, 0);
        // edge lying on the ray
        add_row(0, 5, -100, 5, 100, 5, 1, 0, 0, 0);
        // coordinate extremes
        add_row(-32768, -32768, 32767, -32768, 32767, 32767, 1, 0, 0, 0);
        add_row(32767, 32767, -32768, 32767, 32767, -32768, 1, 0, 0, 0);
        add_row(-32768, -32768, -32768, -32768, -32768, -32768, 1, 1, 1, 1);
        add_row(32767, 32767, 32767, 32767, 32767, 32767, 1, 1, 1, 1);
        add_row(-32768, 0, 32767, -1, 32767, 1, 1, 0, 0, 0);
        // point moves while the count keeps running
        add_row(0, 0, 10, -10, 10, 10, 0, 0, 0, 0);
        add_row(1000, 1000, 10, -10, 10, 10, 0, 0, 0, 0);
        add_row(-50, 0, 10, -10, 10, 10, 1, 0, 0, 0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_edge(dir_rows[i].req, dir_rows[i].typed,
                      dir_rows[i].t_inside, dir_rows[i].t_count);
        run_random(300);

        send_idle = 52;
        recv_idle = 35;
        run_random(580);
        send_saturating(1040);

        send_idle = 0;
        recv_idle = 0;
        run_random(1880);
        in_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### point_in_polygon_ray_cast.f
rtl/core/pipr_pkg.sv
rtl/core/pipr_front.sv
rtl/core/pipr_queue.sv
rtl/core/pipr_back.sv
rtl/core/point_in_polygon_ray_cast.sv
tb/testbench.sv
